>>> design/mkec_pkg.sv
// Package for the modifier key edge counter.
// Holds the shared types, register indexes and sizing constants.
// No dependencies.
package mkec_pkg;

    // Width of the keyboard bitmap and of the fixed result fields.
    localparam int KEY_BITS         = 16;
    localparam int POS_W            = 4;
    localparam int COUNT_W          = 8;
    localparam int KEY_IDX_W        = 4;

    // Default sizing of the counter array.
    localparam int NUM_KEYS_DEF     = 16;
    localparam int COUNT_LIMIT_DEF  = 240;

    // Queue depths between the front, the back and the result port.
    localparam int JOB_DEPTH        = 2;
    localparam int OUT_DEPTH        = 4;

    // Configuration register indexes.
    localparam logic CFG_CTRL_POS   = 1'b0;
    localparam logic CFG_SHIFT_POS  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0] CTRL_POS_RST  = 4'd5;
    localparam logic [POS_W-1:0] SHIFT_POS_RST = 4'd4;

    // Which view a counter belongs to.
    typedef enum logic [1:0] {
        VIEW_PLAIN = 2'd0,
        VIEW_CTRL  = 2'd1,
        VIEW_SHIFT = 2'd2
    } t_view;

    // One counter report as it sits in the result queue.
    typedef struct packed {
        t_view                  view_mode;
        logic [KEY_IDX_W-1:0]   key_index;
        logic [COUNT_W-1:0]     press_count;
        logic                   wrapped;
        logic                   last_of_run;
    } t_result;

endpackage

>>> design/modifier_key_edge_counter.sv
// Top level of the modifier key edge counter.
// Depends on mkec_pkg, mkec_front, mkec_back and mkec_fifo.
//
// Usage: keyboard samples enter through a queue-style port (push/full); a
// sample is taken at a clock edge with push high and full low. Counter
// reports leave through a queue-style port (empty/pop); the head report
// sits on the o_ ports while empty is low and is taken with pop.
// Configuration (ctrl and shift bit positions) is written through
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
// The front classifies each sample in the cycle it is taken and queues an
// edge mask in a two-entry job queue; samples without edges queue nothing.
// The back walks each job over all 3*NUM_KEYS slots (48 by default), one
// counter slot per cycle unless a hit waits for room in the result queue,
// so a sample with edges holds the back for the whole walk; the report of
// slot zero passes the job queue, slot walker, update stage and result queue.
// Reports go through a four-entry result queue; when the receiver stops
// popping, the back waits on a report slot, the job queue fills and full
// rises, so nothing is lost. Reset empties both queues, clears the stored
// views and counters and restores the default bit positions.
module modifier_key_edge_counter import mkec_pkg::*; #(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [POS_W-1:0]        i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [KEY_BITS-1:0]     i_keyboard_bits,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_view_mode,
    output logic [KEY_IDX_W-1:0]    o_key_index,
    output logic [COUNT_W-1:0]      o_press_count,
    output logic                    o_wrapped,
    output logic                    o_last_of_run
);

    localparam int SLOTS = 3 * NUM_KEYS;

    logic                           job_push, job_pop, job_empty;
    logic [SLOTS-1:0]               job_wdata, job_rdata;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
    logic                           out_push;
    t_result                        out_wdata, out_rdata;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           out_full;

    // Front: views and edge detection.
    mkec_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_keyboard_bits (i_keyboard_bits),
        .i_job_full      (full),
        .o_job_push      (job_push),
        .o_job_mask      (job_wdata)
    );

    // Job queue between front and back.
    mkec_fifo #(
        .WIDTH (SLOTS),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_wdata),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_rdata (job_rdata),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    // Back: counter updates.
    mkec_back #(
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty || (job_count == '0)),
        .i_job_mask  (job_rdata),
        .o_job_pop   (job_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata)
    );

    // Result queue; the back never pushes into a full queue.
    mkec_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push && !out_full),
        .i_wdata (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_view_mode   = out_rdata.view_mode;
    assign o_key_index   = out_rdata.key_index;
    assign o_press_count = out_rdata.press_count;
    assign o_wrapped     = out_rdata.wrapped;
    assign o_last_of_run = out_rdata.last_of_run;

endmodule

>>> design/mkec_fifo.sv
// Small synchronous FIFO built from registers.
// Used for the job queue and the result queue; depends on nothing.
module mkec_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_wdata,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_count  = r_count;
    assign o_rdata  = r_data[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> design/mkec_front.sv
// Front end: configuration registers, view forming and edge detection.
// Emits one edge mask per sample that has edges; uses mkec_pkg.
module mkec_front import mkec_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [POS_W-1:0]        i_cfg_data,
    input  logic                    i_push,
    input  logic [KEY_BITS-1:0]     i_keyboard_bits,
    input  logic                    i_job_full,
    output logic                    o_job_push,
    output logic [3*NUM_KEYS-1:0]   o_job_mask
);

    logic [POS_W-1:0]    r_ctrl_pos;
    logic [POS_W-1:0]    r_shift_pos;
    logic [KEY_BITS-1:0] r_prev_plain;
    logic [KEY_BITS-1:0] r_prev_ctrl;
    logic [KEY_BITS-1:0] r_prev_shift;
    logic [KEY_BITS-1:0] cur_ctrl, cur_shift;
    logic [KEY_BITS-1:0] edge_plain, edge_ctrl, edge_shift;
    logic                accept;

    assign accept = i_push && !i_job_full;

    // Configuration registers; writes to unknown indexes cannot occur.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_pos  <= CTRL_POS_RST;
            r_shift_pos <= SHIFT_POS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_CTRL_POS) begin
                r_ctrl_pos <= i_cfg_data;
            end else begin
                r_shift_pos <= i_cfg_data;
            end
        end
    end

    // Modifier views and rising edges. A plain edge counts only when no
    // modifier view holds the key in this sample.
    always_comb begin
        cur_ctrl   = i_keyboard_bits[r_ctrl_pos]  ? i_keyboard_bits : '0;
        cur_shift  = i_keyboard_bits[r_shift_pos] ? i_keyboard_bits : '0;
        edge_plain = i_keyboard_bits & ~r_prev_plain & ~cur_ctrl & ~cur_shift;
        edge_ctrl  = cur_ctrl  & ~r_prev_ctrl;
        edge_shift = cur_shift & ~r_prev_shift;
    end

    // Key-major mask: bit 3*k + view. Keys past the bitmap never fire.
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_mask
        if (k < KEY_BITS) begin : g_live
            assign o_job_mask[3*k + 0] = edge_plain[k];
            assign o_job_mask[3*k + 1] = edge_ctrl[k];
            assign o_job_mask[3*k + 2] = edge_shift[k];
        end else begin : g_dead
            assign o_job_mask[3*k +: 3] = 3'b000;
        end
    end

    // Samples without edges only update the stored views.
    assign o_job_push = accept && (o_job_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_plain <= '0;
            r_prev_ctrl  <= '0;
            r_prev_shift <= '0;
        end else if (accept) begin
            r_prev_plain <= i_keyboard_bits;
            r_prev_ctrl  <= cur_ctrl;
            r_prev_shift <= cur_shift;
        end
    end

endmodule

>>> design/mkec_back.sv
// Back end: walks each edge mask slot by slot, updates the press counter
// memory and writes reports into the result queue; uses mkec_pkg.
module mkec_back import mkec_pkg::*; #(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_empty,
    input  logic [3*NUM_KEYS-1:0]           i_job_mask,
    output logic                            o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]  i_out_count,
    output logic                            o_out_push,
    output t_result                         o_out_data
);

    localparam int SLOTS = 3 * NUM_KEYS;
    localparam int AW    = $clog2(SLOTS);
    localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);

    // Scan state.
    logic              r_busy;
    logic [SLOTS-1:0]  r_pend;
    logic [KW-1:0]     r_key;
    t_view             r_view;
    logic [AW-1:0]     r_addr;

    // Counter memory with a valid bit per entry; invalid reads as zero.
    logic [COUNT_W-1:0] r_count_mem [SLOTS];
    logic [SLOTS-1:0]   r_cnt_valid;
    logic [COUNT_W-1:0] r_rd_data;
    logic               r_rd_valid;

    // Update stage.
    logic              r_s2_valid;
    logic [AW-1:0]     r_s2_addr;
    t_view             r_s2_view;
    logic [KW-1:0]     r_s2_key;
    logic              r_s2_last;

    logic               hit, last_hit, space, advance, end_slot, load;
    logic [COUNT_W-1:0] cur_count, new_count;
    logic [COUNT_W:0]   inc_count;
    logic               wrap;
    t_view              next_view;

    assign hit      = r_pend[0];
    assign last_hit = hit && ((r_pend >> 1) == '0);
    assign space    = ((OCW+1)'(i_out_count) + (OCW+1)'(r_s2_valid)) < (OCW+1)'(OUT_DEPTH);
    assign advance  = r_busy && (!hit || space);
    assign end_slot = (r_key == KW'(NUM_KEYS - 1)) && (r_view == VIEW_SHIFT);
    assign load     = (!r_busy || (advance && end_slot)) && !i_job_empty;
    assign o_job_pop = load;

    // View order within a key: plain, ctrl, shift.
    always_comb begin
        unique case (r_view)
            VIEW_PLAIN: next_view = VIEW_CTRL;
            VIEW_CTRL:  next_view = VIEW_SHIFT;
            VIEW_SHIFT: next_view = VIEW_PLAIN;
            default:    next_view = VIEW_PLAIN;
        endcase
    end

    // Slot walker; the next job starts right after the last slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= '0;
            r_key  <= '0;
            r_view <= VIEW_PLAIN;
            r_addr <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_pend <= i_job_mask;
            r_key  <= '0;
            r_view <= VIEW_PLAIN;
            r_addr <= '0;
        end else if (advance) begin
            r_pend <= r_pend >> 1;
            r_view <= next_view;
            r_addr <= r_addr + 1'b1;
            if (r_view == VIEW_SHIFT) begin
                r_key <= r_key + 1'b1;
            end
            if (end_slot) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Counter read for the current slot. Adjacent slots never share an
    // address, so the write one stage later cannot collide with the read.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_count_mem[r_addr];
        if (r_s2_valid) begin
            r_count_mem[r_s2_addr] <= new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            r_rd_valid <= r_cnt_valid[r_addr];
            r_s2_valid <= advance && hit;
            if (r_s2_valid) begin
                r_cnt_valid[r_s2_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr <= r_addr;
        r_s2_view <= r_view;
        r_s2_key  <= r_key;
        r_s2_last <= last_hit;
    end

    // Increment with wrap at the limit.
    always_comb begin
        cur_count = r_rd_valid ? r_rd_data : '0;
        inc_count = (COUNT_W+1)'(cur_count) + 1'b1;
        wrap      = inc_count >= (COUNT_W+1)'(COUNT_LIMIT);
        new_count = wrap ? '0 : inc_count[COUNT_W-1:0];
    end

    // Report for the result queue.
    always_comb begin
        o_out_push              = r_s2_valid;
        o_out_data.view_mode    = r_s2_view;
        o_out_data.key_index    = KEY_IDX_W'(r_s2_key);
        o_out_data.press_count  = new_count;
        o_out_data.wrapped      = wrap;
        o_out_data.last_of_run  = r_s2_last;
    end

endmodule

>>> design/mkec_checker.sv
// Port-level checker for the modifier key edge counter, bound to the top.
// Depends on mkec_pkg and modifier_key_edge_counter.
module mkec_checker import mkec_pkg::*; #(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  full,
    input  logic                  empty,
    input  logic [1:0]            o_view_mode,
    input  logic [COUNT_W-1:0]    o_press_count,
    input  logic                  o_wrapped
);

    // Reset leaves both queues empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A report never carries an unused view code.
    a_view_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_view_mode == VIEW_PLAIN || o_view_mode == VIEW_CTRL ||
                    o_view_mode == VIEW_SHIFT))
        else $error("bad view code in report");

    // A wrapped counter reads zero.
    a_wrap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_wrapped) |-> (o_press_count == '0))
        else $error("wrapped report with nonzero count");

    // Counts stay below the limit.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((COUNT_W+1)'(o_press_count) < (COUNT_W+1)'(COUNT_LIMIT)))
        else $error("count at or above limit");

endmodule

bind modifier_key_edge_counter mkec_checker #(
    .COUNT_LIMIT (COUNT_LIMIT)
) u_mkec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .o_view_mode   (o_view_mode),
    .o_press_count (o_press_count),
    .o_wrapped     (o_wrapped)
);
